FILE: rtl/spa_pkg.sv
package spa_pkg;

  localparam int unsigned HomingRetryLimit = 400;
  localparam int unsigned Microsteps       = 256;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_TARGET   = 3'd1,
    CMD_HOME     = 3'd2,
    CMD_RESETPOS = 3'd3,
    CMD_FREE_ON  = 3'd4,
    CMD_FREE_OFF = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ACCEL   = 3'd0,
    REG_SPEED   = 3'd1,
    REG_STEPS   = 3'd2,
    REG_ENCODER = 3'd3,
    REG_LIMIT   = 3'd4
  } reg_idx_t;

  localparam logic [1:0] WAIT_1MS  = 2'd0;
  localparam logic [1:0] WAIT_10MS = 2'd1;
  localparam logic [1:0] WAIT_20MS = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] target_position;
    logic [7:0]         index_pulses;
    logic signed [31:0] encoder_position;
    logic signed [15:0] limit_reading;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] velocity_command;
    logic               driver_enabled;
    logic               arrived;
    logic               homing_active;
    logic               clear_encoder;
    logic [1:0]         next_wait;
    logic signed [31:0] position_now;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_word_t;

endpackage

FILE: rtl/spa_if.sv
interface spa_in_if;
  logic             valid;
  logic             ready;
  spa_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spa_out_if;
  logic              valid;
  logic              ready;
  spa_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spa_cfg_if;
  logic              valid;
  logic              ready;
  spa_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/spa_mul.sv
// shift-add multiplier, one multiplier bit per cycle
module spa_mul #(
  parameter int unsigned AW = 64,
  parameter int unsigned BW = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic               done,
  output logic [AW+BW-1:0]   p
);
  localparam int unsigned CW = $clog2(BW + 1);
  logic [AW+BW-1:0] acc;
  logic [AW+BW-1:0] mc;
  logic [BW-1:0]    mb;
  logic [CW-1:0]    cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        acc  <= '0;
        mc   <= {{BW{1'b0}}, a};
        mb   <= b;
        cnt  <= '0;
      end else if (busy) begin
        if (mb[0]) acc <= acc + mc;
        mc  <= mc << 1;
        mb  <= mb >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign p = acc + ((busy && mb[0]) ? mc : '0);
endmodule

FILE: rtl/spa_div.sv
// restoring divider of a 128-bit dividend by a 64-bit divisor, one quotient bit per cycle
module spa_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         done,
  output logic         sat,
  output logic [63:0]  quo
);
  logic [63:0] hi;
  logic [63:0] lo;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] sh;
  logic [64:0] diff;

  always_comb begin
    sh   = {hi, lo[63]};
    diff = sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sat <= (den == '0) || (num[127:64] >= den);
        hi  <= num[127:64];
        lo  <= num[63:0];
        quo <= '0;
        cnt <= '0;
        busy <= !((den == '0) || (num[127:64] >= den));
        done <= (den == '0) || (num[127:64] >= den);
      end else if (busy) begin
        lo <= lo << 1;
        if (!diff[64]) begin
          hi  <= diff[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          hi  <= sh[63:0];
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: rtl/stepper_position_approach.sv
// Results: a non-tick word, or a tick that arrives or homes on a zero reading, has its
//   result in the cycle after acceptance; a tick that moves first passes through S_M1,
//   S_M2, S_D1, S_M3, S_D2, S_M4, S_DIV and S_FIN (three 64-bit serial multiplies and
//   three divides, one bit per cycle). One word at a time: the result waits in S_OUT
//   until taken, and the next word is taken the cycle after the result is taken.
// Reset: synchronous, active high; config to accel 100, speed 300, steps 200, encoder
//   and limit off; tracking state to zero, driver enabled.
module stepper_position_approach #(
  parameter int unsigned HOMING_RETRY_LIMIT = spa_pkg::HomingRetryLimit,
  parameter int unsigned MICROSTEPS         = spa_pkg::Microsteps
) (
  input  logic clk,
  input  logic rst,
  spa_in_if.sink    in_ch,
  spa_out_if.source out_ch,
  spa_cfg_if.sink   cfg_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M2, S_D1, S_M3, S_D2, S_M4, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state;
  logic [15:0] accel, vmaxr, steps;
  logic        enc_on, lim_on;

  logic signed [31:0] pos, tgt, spd, dvel;
  logic homing, pending, departed, idle_arr, enabled;
  logic [8:0] retry;
  logic signed [31:0] dst;
  logic [1:0] wait_r;
  logic arr_r, clr_r, enc_mode;

  logic [63:0] m_val, vmax_val, step_val, den_val;
  logic        mstart;
  logic [63:0] ma, mb;
  logic        mdone;
  logic [127:0] mp;
  logic        dstart, ddone, dsat;
  logic [63:0] dq;

  spa_mul #(.AW(64), .BW(64)) u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp));
  spa_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(mp), .den(den_val),
    .done(ddone), .sat(dsat), .quo(dq));

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  // approach arithmetic values
  logic [31:0] dmag;
  logic [63:0] sug;
  logic signed [65:0] s_v, lo_b, hi_b, ns;
  logic signed [31:0] ns32;
  always_comb begin
    dmag = mag32(dst);
    sug  = (dsat || dq > vmax_val) ? vmax_val : dq;
    s_v  = dst[31] ? -$signed({2'b0, sug}) : $signed({2'b0, sug});
    lo_b = 66'(spd) - $signed({2'b0, step_val});
    hi_b = 66'(spd) + $signed({2'b0, step_val});
    ns   = s_v;
    if (ns < lo_b) ns = lo_b;
    if (ns > hi_b) ns = hi_b;
    if (ns > 66'sd2147483647) ns = 66'sd2147483647;
    if (ns < -66'sd2147483648) ns = -66'sd2147483648;
    ns32 = ns[31:0];
  end

  always_ff @(posedge clk) begin
    logic signed [31:0] ptmp;
    logic signed [31:0] dtmp;
    logic done_t;
    if (rst) begin
      state <= S_IDLE;
      accel <= 16'd100; vmaxr <= 16'd300; steps <= 16'd200;
      enc_on <= 1'b0; lim_on <= 1'b0;
      pos <= '0; tgt <= '0; spd <= '0; dvel <= '0;
      homing <= 1'b0; pending <= 1'b0; departed <= 1'b0; idle_arr <= 1'b0;
      enabled <= 1'b1; retry <= '0;
      mstart <= 1'b0; dstart <= 1'b0;
      arr_r <= 1'b0; clr_r <= 1'b0; wait_r <= spa_pkg::WAIT_1MS;
    end else begin
      mstart <= 1'b0;
      dstart <= 1'b0;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.data.index)
          spa_pkg::REG_ACCEL:   accel  <= cfg_ch.data.data[15:0];
          spa_pkg::REG_SPEED:   vmaxr  <= cfg_ch.data.data[15:0];
          spa_pkg::REG_STEPS:   steps  <= cfg_ch.data.data[15:0];
          spa_pkg::REG_ENCODER: enc_on <= cfg_ch.data.data[0];
          spa_pkg::REG_LIMIT:   lim_on <= cfg_ch.data.data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          arr_r <= 1'b0; clr_r <= 1'b0; wait_r <= spa_pkg::WAIT_1MS;
          state <= S_OUT;
          unique case (in_ch.data.cmd)
            spa_pkg::CMD_TICK: begin
              done_t = 1'b0;
              ptmp = pos;
              dtmp = '0;
              if (idle_arr) begin
                idle_arr <= 1'b0;
                if (pending) departed <= 1'b1;
              end
              if (homing) begin
                if (!lim_on) begin
                  homing <= 1'b0;
                  done_t = 1'b1;
                end else if (in_ch.data.limit_reading == '0) begin
                  dvel <= '0; spd <= '0; pos <= '0; tgt <= '0;
                  clr_r <= enc_on;
                  if (retry < 9'd511) retry <= retry + 1'b1;
                  if (((retry < 9'd511) ? 32'(retry) + 32'd1 : 32'(retry))
                      >= 32'(HOMING_RETRY_LIMIT)) begin
                    homing <= 1'b0;
                    done_t = 1'b1;
                  end else begin
                    wait_r <= spa_pkg::WAIT_10MS;
                  end
                end else begin
                  clr_r <= enc_on;
                  if (in_ch.data.limit_reading > 16'sd250)
                    dtmp = 32'sd30;
                  else if (in_ch.data.limit_reading < -16'sd250)
                    dtmp = -32'sd30;
                  else if (in_ch.data.limit_reading < 0)
                    dtmp = -32'sd1;
                  else
                    dtmp = 32'sd1;
                  tgt <= dtmp;
                  pos <= '0;
                  // approach with encoder 0 and no pulses
                  if (!enc_on && spd > 0) ptmp = 32'sd0; else ptmp = 32'sd0;
                  dst <= dtmp;
                  enc_mode <= enc_on;
                  state <= S_M1;
                end
              end else begin
                if (enc_on) begin
                  ptmp = in_ch.data.encoder_position;
                end else begin
                  ptmp = (spd > 0) ? pos + 32'(in_ch.data.index_pulses)
                                   : pos - 32'(in_ch.data.index_pulses);
                end
                pos <= ptmp;
                dtmp = tgt - ptmp;
                if (dtmp == '0) done_t = 1'b1;
                else begin
                  dst <= dtmp;
                  enc_mode <= enc_on;
                  state <= S_M1;
                end
              end
              if (done_t) begin
                spd <= '0; dvel <= '0;
                if (pending && (departed || (idle_arr && pending))) begin
                  arr_r <= 1'b1; pending <= 1'b0; departed <= 1'b0;
                end
                idle_arr <= 1'b1;
                wait_r <= spa_pkg::WAIT_20MS;
              end
            end
            spa_pkg::CMD_TARGET: if (!homing) begin
              tgt <= in_ch.data.target_position; pending <= 1'b1;
            end
            spa_pkg::CMD_HOME: begin
              homing <= 1'b1; retry <= '0; pending <= 1'b1;
            end
            spa_pkg::CMD_RESETPOS: begin
              dvel <= '0; spd <= '0; pos <= '0; tgt <= '0; clr_r <= enc_on;
            end
            spa_pkg::CMD_FREE_ON: enabled <= 1'b0;
            spa_pkg::CMD_FREE_OFF: begin
              tgt <= enc_on ? in_ch.data.encoder_position : pos;
              spd <= '0; dvel <= '0; enabled <= 1'b1;
            end
            default: ;
          endcase
        end
        // M = A*S*MICROSTEPS
        S_M1: begin
          ma <= 64'(accel); mb <= 64'(steps) * 64'(MICROSTEPS);
          mstart <= 1'b1; state <= S_M2;
        end
        // step = M / 6000
        S_M2: if (mdone) begin
          m_val   <= mp[63:0];
          den_val <= 64'd6000;
          dstart  <= 1'b1; state <= S_D1;
        end
        S_D1: if (ddone) begin
          step_val <= dq;
          ma <= 64'(vmaxr); mb <= 64'(steps) * 64'(MICROSTEPS);
          mstart <= 1'b1; state <= S_M3;
        end
        // vmax = R*S*MICROSTEPS / 60
        S_M3: if (mdone) begin
          den_val <= 64'd60;
          dstart  <= 1'b1; state <= S_D2;
        end
        S_D2: if (ddone) begin
          vmax_val <= dq;
          den_val  <= (enc_mode ? 64'd600 : 64'd60) * 64'(mag32(spd));
          ma <= 64'(dmag) * (enc_mode ? 64'd512 : 64'd1024);
          mb <= m_val;
          mstart <= 1'b1; state <= S_M4;
        end
        S_M4: if (mdone) begin
          dstart <= 1'b1; state <= S_DIV;
        end
        S_DIV: if (ddone) state <= S_FIN;
        S_FIN: begin
          state <= S_OUT;
          if (enc_mode) begin
            if (dmag > 32'd10) begin
              spd <= ns32; dvel <= ns32; wait_r <= spa_pkg::WAIT_10MS;
            end else begin
              if (spd == '0) begin
                spd  <= (ns32 != '0) ? ns32 : 32'(dst * 32'sd2560);
                dvel <= (ns32 != '0) ? ns32 : 32'(dst * 32'sd2560);
              end
              wait_r <= spa_pkg::WAIT_1MS;
            end
          end else begin
            spd <= ns32;
            if (dmag > 32'd1) begin
              dvel <= ns32; wait_r <= spa_pkg::WAIT_10MS;
            end else begin
              if (ns32 == '0) dvel <= '0;
              wait_r <= spa_pkg::WAIT_1MS;
            end
          end
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_ch.data.velocity_command = dvel;
    out_ch.data.driver_enabled   = enabled;
    out_ch.data.arrived          = arr_r;
    out_ch.data.homing_active    = homing;
    out_ch.data.clear_encoder    = clr_r;
    out_ch.data.next_wait        = wait_r;
    out_ch.data.position_now     = pos;
  end
endmodule

FILE: sim/tb_stepper_position_approach.sv
`timescale 1ns / 1ps
module tb_stepper_position_approach;

  logic clk;
  logic rst;
  spa_in_if  in_ch();
  spa_out_if out_ch();
  spa_cfg_if cfg_ch();

  stepper_position_approach u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predictor state
  longint unsigned m_accel = 100, m_speed = 300, m_steps = 200, m_enc = 0, m_lim = 0;
  longint pos_trk = 0, tgt = 0, spd = 0, drv = 0;
  bit homing = 0, pending = 0, departed = 0, idle_arr = 0, enabled = 1;
  int unsigned retries = 0;

  spa_pkg::in_word_t   word_q[$];
  spa_pkg::out_word_t  result_q[$];
  spa_pkg::cfg_word_t  cfg_q[$];
  int errors = 0;
  bit quiet = 0;
  bit cfg_busy = 0;
  bit timed_out = 0;
  int stall_cnt = 0;
  int idle_cnt = 0;

  function automatic longint wrap32(longint x);
    return longint'(int'(x));
  endfunction

  function automatic longint unsigned mag(longint x);
    return x < 0 ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint unsigned muldiv_cap(longint unsigned a, longint unsigned mm,
                                                 longint unsigned b, longint unsigned cap);
    logic [127:0] p;
    logic [127:0] q;
    if (b == 0) return cap;
    p = 128'(a) * 128'(mm);
    q = p / 128'(b);
    if (q[127:64] != 0) return cap;
    return q[63:0] < cap ? q[63:0] : cap;
  endfunction

  function automatic longint calc_speed(longint dst, longint unsigned gain,
                                        longint unsigned dv);
    longint unsigned mm, vmax, sug;
    longint stp, s;
    mm = m_accel * m_steps * 256;
    vmax = m_speed * m_steps * 256 / 60;
    stp = longint'(mm / 6000);
    sug = muldiv_cap(mag(dst) * gain, mm, dv * mag(spd), vmax);
    s = dst < 0 ? -longint'(sug) : longint'(sug);
    if (s < spd - stp) s = spd - stp;
    if (s > spd + stp) s = spd + stp;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  function automatic bit approach_step(longint epos, longint unsigned pulses,
                                       ref logic [1:0] nw);
    longint dst, ns;
    if (m_enc != 0) begin
      pos_trk = epos;
      dst = wrap32(tgt - epos);
      if (dst == 0) return 1;
      ns = calc_speed(dst, 512, 600);
      if (mag(dst) > 10) begin
        spd = ns; drv = ns; nw = spa_pkg::WAIT_10MS;
      end else begin
        if (spd == 0) begin
          spd = ns != 0 ? ns : dst * 2560;
          drv = spd;
        end
        nw = spa_pkg::WAIT_1MS;
      end
      return 0;
    end
    pos_trk = wrap32(spd > 0 ? pos_trk + longint'(pulses) : pos_trk - longint'(pulses));
    dst = wrap32(tgt - pos_trk);
    if (dst == 0) return 1;
    spd = calc_speed(dst, 1024, 60);
    if (mag(dst) > 1) begin
      drv = spd; nw = spa_pkg::WAIT_10MS;
    end else begin
      if (spd == 0) drv = 0;
      nw = spa_pkg::WAIT_1MS;
    end
    return 0;
  endfunction

  function automatic void zero_position();
    drv = 0; spd = 0; pos_trk = 0; tgt = 0;
  endfunction

  function automatic spa_pkg::out_word_t predict_motion(spa_pkg::in_word_t w);
    spa_pkg::out_word_t r;
    logic [1:0] nw;
    bit clr, arr, done;
    longint lim, sg;
    nw = spa_pkg::WAIT_1MS; clr = 0; arr = 0;
    lim = longint'(w.limit_reading);
    case (w.cmd)
      spa_pkg::CMD_TICK: begin
        if (idle_arr) begin
          idle_arr = 0;
          if (pending) departed = 1;
        end
        if (homing) begin
          done = 0;
          if (m_lim == 0) begin
            homing = 0; done = 1;
          end else if (lim == 0) begin
            zero_position();
            clr = m_enc[0];
            if (retries < 511) retries++;
            if (retries >= spa_pkg::HomingRetryLimit) begin
              homing = 0; done = 1;
            end else nw = spa_pkg::WAIT_10MS;
          end else begin
            sg = lim < 0 ? -1 : 1;
            tgt = (lim > 250 || lim < -250) ? sg * 30 : sg;
            pos_trk = 0;
            clr = m_enc[0];
            void'(approach_step(0, 0, nw));
          end
        end else done = approach_step(longint'(w.encoder_position),
                                      w.index_pulses, nw);
        if (done) begin
          spd = 0; drv = 0;
          if (pending && departed) begin
            arr = 1; pending = 0; departed = 0;
          end
          idle_arr = 1;
          nw = spa_pkg::WAIT_20MS;
        end
      end
      spa_pkg::CMD_TARGET: if (!homing) begin
        tgt = longint'(w.target_position); pending = 1;
      end
      spa_pkg::CMD_HOME: begin
        homing = 1; retries = 0; pending = 1;
      end
      spa_pkg::CMD_RESETPOS: begin
        zero_position(); clr = m_enc[0];
      end
      spa_pkg::CMD_FREE_ON: enabled = 0;
      spa_pkg::CMD_FREE_OFF: begin
        tgt = m_enc != 0 ? longint'(w.encoder_position) : pos_trk;
        spd = 0; drv = 0; enabled = 1;
      end
      default: ;
    endcase
    r.velocity_command = drv[31:0];
    r.driver_enabled = enabled;
    r.arrived = arr;
    r.homing_active = homing;
    r.clear_encoder = clr;
    r.next_wait = nw;
    r.position_now = pos_trk[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // handshake sampling is done at posedge to avoid races
  bit in_acc, cfg_acc;
  always @(posedge clk) begin
    in_acc <= in_ch.valid && in_ch.ready;
    cfg_acc <= cfg_ch.valid && cfg_ch.ready;
  end

  // input driver
  spa_pkg::in_word_t cur_in;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_acc) begin
        result_q.push_back(predict_motion(cur_in));
        void'(word_q.pop_front());
      end
      if (in_ch.valid && !in_acc) begin
      end else if (idle_cnt > 0) begin
        idle_cnt--;
        in_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        idle_cnt = $urandom_range(1, 13);
        in_ch.valid <= 1'b0;
      end else if (word_q.size() > 0 && !cfg_busy) begin
        cur_in = word_q[0];
        in_ch.data <= word_q[0];
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // config driver
  always @(negedge clk) begin
    if (rst) begin
      cfg_ch.valid <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_q[0].index)
          spa_pkg::REG_ACCEL:   m_accel = cfg_q[0].data[15:0];
          spa_pkg::REG_SPEED:   m_speed = cfg_q[0].data[15:0];
          spa_pkg::REG_STEPS:   m_steps = cfg_q[0].data[15:0];
          spa_pkg::REG_ENCODER: m_enc = cfg_q[0].data[0];
          spa_pkg::REG_LIMIT:   m_lim = cfg_q[0].data[0];
          default: ;
        endcase
        void'(cfg_q.pop_front());
      end
      if (cfg_ch.valid && !cfg_acc) begin
      end else if (cfg_q.size() > 0) begin
        cfg_ch.data <= cfg_q[0];
        cfg_ch.valid <= 1'b1;
      end else begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // output monitor and sink stalls
  int out_idle = 0;
  always @(posedge clk) begin
    spa_pkg::out_word_t got, want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          want = result_q.pop_front();
          if (got.velocity_command !== want.velocity_command)
            report_mismatch("velocity_command", got.velocity_command, want.velocity_command);
          if (got.driver_enabled !== want.driver_enabled)
            report_mismatch("driver_enabled", got.driver_enabled, want.driver_enabled);
          if (got.arrived !== want.arrived)
            report_mismatch("arrived", got.arrived, want.arrived);
          if (got.homing_active !== want.homing_active)
            report_mismatch("homing_active", got.homing_active, want.homing_active);
          if (got.clear_encoder !== want.clear_encoder)
            report_mismatch("clear_encoder", got.clear_encoder, want.clear_encoder);
          if (got.next_wait !== want.next_wait)
            report_mismatch("next_wait", got.next_wait, want.next_wait);
          if (got.position_now !== want.position_now)
            report_mismatch("position_now", got.position_now, want.position_now);
        end
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stall_cnt <= 0;
      else
        stall_cnt <= stall_cnt + 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (out_idle > 0) begin
      out_idle--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      out_idle = $urandom_range(1, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (stall_cnt >= 20000 && !timed_out) begin
      timed_out = 1;
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic spa_pkg::in_word_t make_word(spa_pkg::cmd_t c);
    spa_pkg::in_word_t w;
    w.cmd = c;
    w.target_position = $urandom;
    w.index_pulses = 8'($urandom);
    w.encoder_position = $urandom;
    w.limit_reading = 16'($urandom);
    return w;
  endfunction

  function automatic spa_pkg::in_word_t tick_near(longint base, int spread);
    spa_pkg::in_word_t w;
    w = make_word(spa_pkg::CMD_TICK);
    w.index_pulses = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 12));
    w.encoder_position = 32'(base + $urandom_range(0, 2 * spread) - spread);
    case ($urandom_range(0, 5))
      0: w.limit_reading = '0;
      1: w.limit_reading = 16'($urandom_range(0, 500) - 250);
      default: ;
    endcase
    return w;
  endfunction

  task automatic settle();
    while (word_q.size() > 0 || result_q.size() > 0 || cfg_q.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_cfg(spa_pkg::reg_idx_t idx, logic [31:0] v);
    spa_pkg::cfg_word_t c;
    c.index = idx;
    c.data = v;
    cfg_q.push_back(c);
  endtask

  task automatic config_phase(int a, int s, int st, int e, int l);
    settle();
    cfg_busy = 1;
    write_cfg(spa_pkg::REG_ACCEL, a);
    write_cfg(spa_pkg::REG_SPEED, s);
    write_cfg(spa_pkg::REG_STEPS, st);
    write_cfg(spa_pkg::REG_ENCODER, e);
    write_cfg(spa_pkg::REG_LIMIT, l);
    while (cfg_q.size() > 0) @(posedge clk);
    @(posedge clk);
    cfg_busy = 0;
  endtask

  task automatic run_random(int n);
    spa_pkg::in_word_t w;
    longint aim;
    int k, seg;
    k = 0;
    while (k < n) begin
      aim = $urandom_range(0, 3) == 0 ? longint'($signed($urandom)) :
            longint'($urandom_range(0, 4000)) - 2000;
      w = make_word(spa_pkg::CMD_TARGET);
      w.target_position = 32'(aim);
      word_q.push_back(w); k++;
      seg = $urandom_range(3, 20);
      repeat (seg) begin
        word_q.push_back(tick_near(aim, 40)); k++;
      end
      case ($urandom_range(0, 9))
        0: begin word_q.push_back(make_word(spa_pkg::CMD_HOME)); k++; end
        1: begin word_q.push_back(make_word(spa_pkg::CMD_RESETPOS)); k++; end
        2: begin word_q.push_back(make_word(spa_pkg::CMD_FREE_ON)); k++; end
        3: begin word_q.push_back(make_word(spa_pkg::CMD_FREE_OFF)); k++; end
        4: begin
          w = make_word(spa_pkg::CMD_TICK);
          w.cmd = 3'($urandom_range(6, 7));
          word_q.push_back(w); k++;
        end
        5: begin word_q.push_back(make_word(spa_pkg::CMD_TICK)); k++; end
        default: ;
      endcase
      while (word_q.size() > 8) @(posedge clk);
    end
  endtask

  initial begin
    spa_pkg::in_word_t w;
    int i;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every command, extremes, homing without sensor
    w = make_word(spa_pkg::CMD_TARGET); w.target_position = 32'sh7fffffff; word_q.push_back(w);
    w = make_word(spa_pkg::CMD_TICK); w.index_pulses = 8'hff; word_q.push_back(w);
    w = make_word(spa_pkg::CMD_TICK); w.index_pulses = '0; word_q.push_back(w);
    w = make_word(spa_pkg::CMD_TARGET); w.target_position = 32'sh80000000; word_q.push_back(w);
    w = make_word(spa_pkg::CMD_TICK); word_q.push_back(w);
    word_q.push_back(make_word(spa_pkg::CMD_FREE_ON));
    word_q.push_back(make_word(spa_pkg::CMD_FREE_OFF));
    word_q.push_back(make_word(spa_pkg::CMD_TICK));
    word_q.push_back(make_word(spa_pkg::CMD_TICK));
    word_q.push_back(make_word(spa_pkg::CMD_HOME));
    word_q.push_back(make_word(spa_pkg::CMD_TARGET));
    word_q.push_back(make_word(spa_pkg::CMD_TICK));
    word_q.push_back(make_word(spa_pkg::CMD_RESETPOS));
    w = make_word(spa_pkg::CMD_TICK); w.cmd = 3'd6; word_q.push_back(w);
    w = make_word(spa_pkg::CMD_TICK); w.cmd = 3'd7; word_q.push_back(w);
    run_random(180);

    // limit sensor, homing paths
    config_phase(100, 300, 200, 0, 1);
    word_q.push_back(make_word(spa_pkg::CMD_HOME));
    w = make_word(spa_pkg::CMD_TICK); w.limit_reading = 16'sh7fff; word_q.push_back(w);
    w = make_word(spa_pkg::CMD_TICK); w.limit_reading = 16'sh8000; word_q.push_back(w);
    w = make_word(spa_pkg::CMD_TICK); w.limit_reading = 16'sd5; word_q.push_back(w);
    for (i = 0; i < 402; i++) begin
      w = make_word(spa_pkg::CMD_TICK); w.limit_reading = '0; word_q.push_back(w);
      while (word_q.size() > 8) @(posedge clk);
    end
    run_random(100);

    config_phase(65535, 65535, 65535, 1, 1);
    word_q.push_back(make_word(spa_pkg::CMD_HOME));
    w = make_word(spa_pkg::CMD_TICK); w.limit_reading = '0; word_q.push_back(w);
    word_q.push_back(make_word(spa_pkg::CMD_RESETPOS));
    run_random(150);
    config_phase(0, 0, 1, 1, 0);
    run_random(100);
    config_phase($urandom_range(1, 2000), $urandom_range(1, 3000),
                 $urandom_range(1, 4000), 1, 1);
    run_random(150);
    config_phase($urandom, $urandom, $urandom_range(1, 65535), 0, 0);
    run_random(150);
    quiet = 1;
    config_phase(100, 300, 200, 0, 1);
    run_random(100);

    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/spa_pkg.sv
rtl/spa_if.sv
rtl/spa_mul.sv
rtl/spa_div.sv
rtl/stepper_position_approach.sv
sim/tb_stepper_position_approach.sv
